[sv/ffud_pkg.sv]
// shared types, constants and helpers for the form field url decoder
// no dependencies; imported by every module of the block

package ffud_pkg;

  // sizing
  localparam int RAW_BUFFER_BYTES = 128;
  localparam int MAX_KEY_CHARS    = 8;
  localparam int RAW_W            = $clog2(RAW_BUFFER_BYTES);
  localparam int KEY_IDX_W        = $clog2(MAX_KEY_CHARS + 1);
  localparam int QDEPTH           = 4;
  localparam int QPTR_W           = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W           = $clog2(QDEPTH + 1);

  // register indexes
  localparam logic [1:0] CFG_KEY_TEXT   = 2'd0;
  localparam logic [1:0] CFG_KEY_LENGTH = 2'd1;
  localparam logic [1:0] CFG_OUT_CAP    = 2'd2;

  // reset values of the registers
  localparam logic [63:0] KEY_TEXT_RST   = 64'd1684632435;
  localparam logic [3:0]  KEY_LENGTH_RST = 4'd4;
  localparam logic [6:0]  OUT_CAP_RST    = 7'd32;

  // scan phases
  localparam logic [1:0] PH_MATCH = 2'd0;
  localparam logic [1:0] PH_SKIP  = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // escape phases
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_PCT  = 2'd1;
  localparam logic [1:0] ESC_HEX1 = 2'd2;

  // characters
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [63:0] key_text;
    logic [3:0]  key_length;
    logic [6:0]  out_capacity;
  } cfg_t;

  // results of one body byte: up to three decoded bytes and a terminal item
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            term;
    logic            found;
  } bundle_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       seen;
    logic       clear;
  } front_stat_t;

  // hex digit test: {is_hex, nibble}
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

[sv/ffud_front.sv]
// front end: segment scan, key match and url decoding of one body byte a beat
// depends on ffud_pkg; pushes a result bundle for each byte that yields a result or ends the body

module ffud_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ffud_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      body_byte_i,
  input  logic            body_last_i,
  input  logic            q_ready_i,
  output logic            q_push_o,
  output ffud_pkg::bundle_t q_data_o,
  output ffud_pkg::front_stat_t stat_o
);
  import ffud_pkg::*;

  typedef struct packed {
    logic [2:0][7:0] b;
    logic [1:0]      n;
  } acc_t;

  function automatic acc_t push(acc_t a, logic [7:0] x);
    acc_t r;
    r = a;
    if (a.n != 2'd3) begin
      r.b[a.n] = x;
      r.n      = a.n + 2'd1;
    end
    return r;
  endfunction

  // pending '%' and held digit come out as literals
  function automatic acc_t flush(acc_t a, logic [1:0] e, logic [7:0] h);
    acc_t r;
    r = a;
    if (e == ESC_PCT) begin
      r = push(r, CH_PCT);
    end else if (e == ESC_HEX1) begin
      r = push(r, CH_PCT);
      r = push(r, h);
    end
    return r;
  endfunction

  localparam logic [RAW_W-1:0] RAW_LIMIT = RAW_W'(RAW_BUFFER_BYTES - 1);

  logic [1:0]           phase_q, phase_d;
  logic [KEY_IDX_W-1:0] kidx_q, kidx_d;
  logic [1:0]           esc_q, esc_d;
  logic [7:0]           held_q, held_d;
  logic [RAW_W-1:0]     raw_q, raw_d;
  logic [6:0]           emitted_q, emitted_d;
  logic                 seen_q, seen_d;

  logic                 in_acc;
  logic [KEY_IDX_W-1:0] klen;
  logic [7:0]           key_char;
  logic [4:0]           hx_b;
  logic [4:0]           hx_h;
  logic [RAW_W-1:0]     raw_inc;
  acc_t                 acc;
  logic                 done;
  logic [6:0]           room;
  logic [1:0]           n_emit;

  assign in_acc     = in_valid_i && q_ready_i;
  assign in_ready_o = q_ready_i;

  // clamp key length
  assign klen = (cfg_i.key_length > 4'(MAX_KEY_CHARS)) ? KEY_IDX_W'(MAX_KEY_CHARS)
                                                       : KEY_IDX_W'(cfg_i.key_length);
  assign key_char = 8'(cfg_i.key_text >> {kidx_q, 3'b000});
  assign hx_b     = hex_val(body_byte_i);
  assign hx_h     = hex_val(held_q);
  assign raw_inc  = raw_q + RAW_W'(1);

  // next state and candidate bytes for this beat
  always_comb begin
    phase_d = phase_q;
    kidx_d  = kidx_q;
    esc_d   = esc_q;
    held_d  = held_q;
    raw_d   = raw_q;
    seen_d  = seen_q;
    acc     = '0;
    done    = 1'b0;
    case (phase_q)
      PH_MATCH: begin
        if (body_byte_i == CH_AMP) begin
          kidx_d = '0;
        end else if (kidx_q < klen) begin
          if (body_byte_i == key_char) kidx_d = kidx_q + KEY_IDX_W'(1);
          else phase_d = PH_SKIP;
        end else if (body_byte_i == CH_EQ) begin
          phase_d = PH_VALUE;
          seen_d  = 1'b1;
          raw_d   = '0;
          esc_d   = ESC_NONE;
        end else begin
          phase_d = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (body_byte_i == CH_AMP) begin
          phase_d = PH_MATCH;
          kidx_d  = '0;
        end
      end
      PH_VALUE: begin
        if (body_byte_i == CH_AMP) begin
          acc     = flush(acc, esc_q, held_q);
          esc_d   = ESC_NONE;
          phase_d = PH_DONE;
        end else if (raw_q < RAW_LIMIT) begin
          raw_d = raw_inc;
          // escape handling
          if (esc_q == ESC_PCT) begin
            if (hx_b[4]) begin
              held_d = body_byte_i;
              esc_d  = ESC_HEX1;
              done   = 1'b1;
            end else begin
              acc   = flush(acc, esc_q, held_q);
              esc_d = ESC_NONE;
            end
          end else if (esc_q == ESC_HEX1) begin
            if (hx_b[4]) begin
              acc   = push(acc, {hx_h[4] ? hx_h[3:0] : 4'd0, hx_b[3:0]});
              esc_d = ESC_NONE;
              done  = 1'b1;
            end else begin
              acc   = flush(acc, esc_q, held_q);
              esc_d = ESC_NONE;
            end
          end else begin
            esc_d = ESC_NONE;
          end
          // plain byte
          if (!done) begin
            if (body_byte_i == CH_PCT) esc_d = ESC_PCT;
            else if (body_byte_i == CH_PLUS) acc = push(acc, CH_SPACE);
            else acc = push(acc, body_byte_i);
          end
          // raw limit reached
          if (raw_inc == RAW_LIMIT) begin
            acc   = flush(acc, esc_d, held_d);
            esc_d = ESC_NONE;
          end
        end
      end
      default: phase_d = PH_DONE;
    endcase
    // end of body
    if (body_last_i && phase_d == PH_VALUE) begin
      acc   = flush(acc, esc_d, held_d);
      esc_d = ESC_NONE;
    end
  end

  // output capacity gating
  assign room   = (emitted_q < cfg_i.out_capacity) ? (cfg_i.out_capacity - emitted_q) : 7'd0;
  assign n_emit = (room < {5'd0, acc.n}) ? room[1:0] : acc.n;
  assign emitted_d = emitted_q + {5'd0, n_emit};

  // bundle to the queue
  always_comb begin
    q_data_o.bytes  = acc.b;
    q_data_o.nbytes = n_emit;
    q_data_o.term   = body_last_i;
    q_data_o.found  = seen_d;
  end
  assign q_push_o = in_acc && ((n_emit != 2'd0) || body_last_i);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MATCH;
      kidx_q    <= '0;
      esc_q     <= ESC_NONE;
      held_q    <= '0;
      raw_q     <= '0;
      emitted_q <= '0;
      seen_q    <= 1'b0;
    end else if (in_acc) begin
      if (body_last_i) begin
        phase_q   <= PH_MATCH;
        kidx_q    <= '0;
        esc_q     <= ESC_NONE;
        held_q    <= '0;
        raw_q     <= '0;
        emitted_q <= '0;
        seen_q    <= 1'b0;
      end else begin
        phase_q   <= phase_d;
        kidx_q    <= kidx_d;
        esc_q     <= esc_d;
        held_q    <= held_d;
        raw_q     <= raw_d;
        emitted_q <= emitted_d;
        seen_q    <= seen_d;
      end
    end
  end

  // status for checks
  assign stat_o.phase = phase_q;
  assign stat_o.seen  = seen_q;
  assign stat_o.clear = (kidx_q == '0) && (esc_q == ESC_NONE) && (raw_q == '0)
                        && (emitted_q == '0);

endmodule

[sv/ffud_queue.sv]
// short bundle queue between front and back end
// depends on ffud_pkg for the bundle type and depth

module ffud_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ffud_pkg::bundle_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  output ffud_pkg::bundle_t data_o,
  input  logic              pop_i
);
  import ffud_pkg::*;

  bundle_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign ready_o = (count_q != QCNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop) count_q <= count_q + QCNT_W'(1);
      else if (do_pop && !do_push) count_q <= count_q - QCNT_W'(1);
    end
  end

endmodule

[sv/ffud_back.sv]
// back end: walks each bundle and presents its items one beat at a time
// depends on ffud_pkg; the bundle register doubles as the output register

module ffud_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  ffud_pkg::bundle_t q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        value_byte_o,
  output logic              byte_valid_o,
  output logic              run_last_o,
  output logic              key_found_o
);
  import ffud_pkg::*;

  bundle_t    cur_q;
  logic       cur_valid_q;
  logic [1:0] idx_q;
  logic [2:0] n_items;
  logic       last_item;
  logic       take;
  logic       advance;
  logic       is_byte;

  assign n_items   = {1'b0, cur_q.nbytes} + {2'b00, cur_q.term};
  assign last_item = ({1'b0, idx_q} + 3'd1) == n_items;
  assign take      = cur_valid_q && out_ready_i;
  assign advance   = !cur_valid_q || (take && last_item);
  assign q_pop_o   = advance && q_valid_i;

  // current item
  assign is_byte = idx_q < cur_q.nbytes;
  always_comb begin
    case (idx_q)
      2'd0:    value_byte_o = is_byte ? cur_q.bytes[0] : 8'd0;
      2'd1:    value_byte_o = is_byte ? cur_q.bytes[1] : 8'd0;
      2'd2:    value_byte_o = is_byte ? cur_q.bytes[2] : 8'd0;
      default: value_byte_o = 8'd0;
    endcase
  end
  assign out_valid_o  = cur_valid_q;
  assign byte_valid_o = is_byte;
  assign run_last_o   = !is_byte;
  assign key_found_o  = !is_byte && cur_q.found;

  // bundle payload
  always_ff @(posedge clk_i) begin
    if (advance && q_valid_i) cur_q <= q_data_i;
  end

  // walk control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (advance) begin
      cur_valid_q <= q_valid_i;
      idx_q       <= 2'd0;
    end else if (take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

[sv/form_field_url_decoder_unit.sv]
// top level of the form field url decoder: registers, front, queue, back
// depends on ffud_pkg, ffud_front, ffud_queue and ffud_back
//
// usage:
//   body bytes enter on in_valid_i / in_ready_o with body_byte_i and
//   body_last_i, one beat per byte. decoded value bytes and the terminal
//   item leave on out_valid_o / out_ready_i; byte_valid_o marks a decoded
//   byte, run_last_o the terminal item with key_found_o.
//   registers are written on cfg_valid_i with cfg_index_i and cfg_data_i;
//   cfg_ready_o is always high and a write applies from the next byte on.
//   the results of a byte pass through the queue storage and then the
//   bundle register of the back end before they are presented.
//   throughput: one body byte per cycle while each byte yields at most one
//   result and out_ready_i stays high; a byte yielding k results holds the
//   output for k items, since the back end presents one item per cycle.
//   a four bundle queue lets the front keep taking bytes meanwhile.
//   reset clears scan state, queue and output and loads register defaults.
//   when the receiver stalls the queue fills and in_ready_o drops once it
//   holds four bundles; bytes that yield no result still need a free slot.

module form_field_url_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  body_byte_i,
  input  logic        body_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  value_byte_o,
  output logic        byte_valid_o,
  output logic        run_last_o,
  output logic        key_found_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import ffud_pkg::*;

  cfg_t        cfg_q;
  logic        q_push, q_ready, q_valid, q_pop;
  bundle_t     q_in, q_out;
  front_stat_t front_stat;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_text     <= KEY_TEXT_RST;
      cfg_q.key_length   <= KEY_LENGTH_RST;
      cfg_q.out_capacity <= OUT_CAP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_KEY_TEXT:   cfg_q.key_text     <= cfg_data_i;
        CFG_KEY_LENGTH: cfg_q.key_length   <= cfg_data_i[3:0];
        CFG_OUT_CAP:    cfg_q.out_capacity <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  ffud_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .body_byte_i (body_byte_i),
    .body_last_i (body_last_i),
    .q_ready_i   (q_ready),
    .q_push_o    (q_push),
    .q_data_o    (q_in),
    .stat_o      (front_stat)
  );

  ffud_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (q_out),
    .pop_i   (q_pop)
  );

  ffud_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_out),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_byte_o (value_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .key_found_o  (key_found_o)
  );

  // scan state returns to reset after the final body byte
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && body_last_i |=>
      front_stat.clear && !front_stat.seen && (front_stat.phase == PH_MATCH))
    else $error("front state not cleared after final body byte");

  // being inside a value implies the key was seen
  a_value_implies_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_stat.phase == PH_VALUE) |-> front_stat.seen)
    else $error("value phase without a matched key");

  // every presented item is either a byte or the terminal item
  a_item_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_valid_o != run_last_o))
    else $error("output item is neither byte nor terminal");

  // key_found only rides on the terminal item
  a_found_on_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_found_o |-> run_last_o)
    else $error("key_found set on a byte item");

endmodule
